### sv/sva_pkg.sv
// Shared types and constants of the voice allocator.
`default_nettype none
package sva_pkg;

  typedef enum logic [2:0] {
    FUNC_NOTE_ON   = 3'd0,
    FUNC_NOTE_OFF  = 3'd1,
    FUNC_ALL_OFF   = 3'd2,
    FUNC_SAMPLE    = 3'd3,
    FUNC_BLOCK_END = 3'd4
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam logic [7:0] CFG_FLOOR_LEVEL = 8'd0;
  localparam logic [7:0] CFG_QUIET_LIMIT = 8'd1;

  localparam logic [15:0] FLOOR_RESET = 16'd4;
  localparam logic [15:0] LIMIT_RESET = 16'd1536;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  typedef struct packed {
    logic        valid;
    func_e       func;
    logic [6:0]  note;
    logic [31:0] age;
    logic [15:0] level;
    logic [15:0] floor_lvl;
    logic [15:0] limit;
  } cmd_t;

  typedef struct packed {
    logic        free;
    logic [31:0] age;
  } tok_t;

  typedef struct packed {
    logic used_nx;
    logic gate_nx;
    logic free_hit;
    logic trig;
  } sts_t;

endpackage
`default_nettype wire

### sv/sva_in_if.sv
// Input item channel of the voice allocator.
`default_nettype none
interface sva_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  note_number;
  logic [6:0]  note_velocity;
  logic [15:0] mix_level;

  modport source (output valid, output func, output note_number, output note_velocity,
                  output mix_level, input ready);
  modport sink (input valid, input func, input note_number, input note_velocity,
                input mix_level, output ready);
endinterface
`default_nettype wire

### sv/sva_out_if.sv
// Result item channel of the voice allocator.
`default_nettype none
interface sva_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  voice_index;
  logic        stolen;
  logic [15:0] random_value;
  logic [7:0]  gate_mask;
  logic [7:0]  used_mask;
  logic [7:0]  freed_mask;
  logic [7:0]  trigger_mask;

  modport source (output valid, output voice_index, output stolen, output random_value,
                  output gate_mask, output used_mask, output freed_mask,
                  output trigger_mask, input ready);
  modport sink (input valid, input voice_index, input stolen, input random_value,
                input gate_mask, input used_mask, input freed_mask,
                input trigger_mask, output ready);
endinterface
`default_nettype wire

### sv/sva_cfg_if.sv
// Configuration write channel of the voice allocator.
`default_nettype none
interface sva_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/synth_voice_allocator_core.sv
// A note_on item gives its result once the search token has crossed the chain of voice cells;
// the token moves one cell per cycle. Other items give their result without waiting for the token.
// One item is worked on at a time: a new item is taken only after the last one has been applied.
// The result waits in an output register, so the next item may enter while it is not yet taken.
// Reset is asynchronous and active low; it clears all voice state, the age counter and the
// generator at once and loads the floor and limit registers with 4 and 1536.
`default_nettype none
module synth_voice_allocator_core #(
  parameter int unsigned VOICES = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sva_in_if.sink     in_i,
  sva_out_if.source  out_o,
  sva_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MaskN = (VOICES < 8) ? VOICES : 8;
  localparam logic [IdxW-1:0] CntLast = IdxW'(VOICES - 1);

  sva_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  sva_pkg::func_e   func_q;
  logic [6:0]       note_q;
  logic [15:0]      level_q;
  logic [15:0]      floor_q, limit_q;
  logic [31:0]      age_ctr_q;
  logic [31:0]      rng_q, rng_nx;
  logic             apply, out_free;

  logic             out_valid_q;
  logic [2:0]       vidx_q;
  logic             stolen_q;
  logic [15:0]      rnd_q;
  logic [7:0]       gate_m_q, used_m_q, freed_m_q, trig_m_q;
  logic [7:0]       gate_nx_m, used_nx_m, hit_m, trig_m;

  sva_pkg::cmd_t    cmd;
  sva_pkg::tok_t    tok [VOICES];
  sva_pkg::tok_t    tok_in [VOICES];
  logic [IdxW-1:0]  tok_idx [VOICES];
  logic [IdxW-1:0]  tok_idx_in [VOICES];
  sva_pkg::sts_t    sts [VOICES];
  logic             is_note_on;

  assign is_note_on = (func_q == sva_pkg::FUNC_NOTE_ON);
  assign out_free   = !out_valid_q || out_o.ready;
  assign apply      = (state_q == sva_pkg::ST_EXEC) && out_free &&
                      (!is_note_on || (cnt_q == CntLast));

  always_comb begin
    cmd.valid     = apply;
    cmd.func      = func_q;
    cmd.note      = note_q;
    cmd.age       = age_ctr_q + 32'd1;
    cmd.level     = level_q;
    cmd.floor_lvl = floor_q;
    cmd.limit     = limit_q;
  end

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g]     = '0;
      assign tok_idx_in[g] = '0;
    end else begin : g_link
      assign tok_in[g]     = tok[g-1];
      assign tok_idx_in[g] = tok_idx[g-1];
    end
    sva_cell #(
      .IDX_W    (IdxW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .pick_i    (tok_idx[VOICES-1]),
      .tok_i     (tok_in[g]),
      .tok_idx_i (tok_idx_in[g]),
      .tok_o     (tok[g]),
      .tok_idx_o (tok_idx[g]),
      .sts_o     (sts[g])
    );
  end

  always_comb begin
    gate_nx_m = '0;
    used_nx_m = '0;
    hit_m     = '0;
    trig_m    = '0;
    for (int i = 0; i < MaskN; i++) begin
      gate_nx_m[i] = sts[i].gate_nx;
      used_nx_m[i] = sts[i].used_nx;
      hit_m[i]     = sts[i].free_hit;
      trig_m[i]    = sts[i].trig;
    end
  end

  assign rng_nx = rng_q * sva_pkg::LCG_MUL + sva_pkg::LCG_ADD;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_i.ready = 1'b0;
    case (state_q)
      sva_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = sva_pkg::ST_EXEC;
          cnt_d   = '0;
        end
      end
      sva_pkg::ST_EXEC: begin
        if (apply) begin
          state_d = sva_pkg::ST_IDLE;
        end else if (cnt_q != CntLast) begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      default: state_d = sva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sva_pkg::ST_IDLE;
      cnt_q       <= '0;
      age_ctr_q   <= '0;
      rng_q       <= '0;
      floor_q     <= sva_pkg::FLOOR_RESET;
      limit_q     <= sva_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (apply && is_note_on) begin
        age_ctr_q <= age_ctr_q + 32'd1;
        rng_q     <= rng_nx;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          sva_pkg::CFG_FLOOR_LEVEL: floor_q <= cfg_i.data;
          sva_pkg::CFG_QUIET_LIMIT: limit_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q  <= sva_pkg::func_e'(in_i.func);
      note_q  <= in_i.note_number;
      level_q <= in_i.mix_level;
    end
    if (apply) begin
      vidx_q    <= is_note_on ? 3'(tok_idx[VOICES-1]) : 3'd0;
      stolen_q  <= is_note_on && !tok[VOICES-1].free;
      rnd_q     <= is_note_on ? rng_nx[24:9] : 16'd0;
      gate_m_q  <= gate_nx_m;
      used_m_q  <= used_nx_m;
      freed_m_q <= (func_q == sva_pkg::FUNC_BLOCK_END) ? hit_m : 8'd0;
      trig_m_q  <= (func_q == sva_pkg::FUNC_SAMPLE) ? trig_m : 8'd0;
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.voice_index  = vidx_q;
  assign out_o.stolen       = stolen_q;
  assign out_o.random_value = rnd_q;
  assign out_o.gate_mask    = gate_m_q;
  assign out_o.used_mask    = used_m_q;
  assign out_o.freed_mask   = freed_m_q;
  assign out_o.trigger_mask = trig_m_q;

`ifndef SYNTHESIS
  a_stolen_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stolen_q |-> (&used_m_q[MaskN-1:0]))
    else $error("A voice was stolen while a voice was free.");

  a_freed_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((freed_m_q & (used_m_q | gate_m_q)) == 8'd0))
    else $error("A freed voice is still used or gated.");

  a_age_on_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_ctr_q != $past(age_ctr_q)) |-> $past(apply && is_note_on))
    else $error("The age counter moved without a note_on item.");
`endif

endmodule
`default_nettype wire

### sv/sva_cell.sv
// One voice cell: voice state, its update and one stage of the oldest-voice search chain.
`default_nettype none
module sva_cell #(
  parameter int unsigned IDX_W    = 3,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sva_pkg::cmd_t     cmd_i,
  input  wire logic [IDX_W-1:0]  pick_i,
  input  wire sva_pkg::tok_t     tok_i,
  input  wire logic [IDX_W-1:0]  tok_idx_i,
  output sva_pkg::tok_t          tok_o,
  output logic [IDX_W-1:0]       tok_idx_o,
  output sva_pkg::sts_t          sts_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic        used_q, used_d;
  logic        gate_q, gate_d;
  logic [6:0]  note_q, note_d;
  logic [31:0] age_q, age_d;
  logic [15:0] quiet_q, quiet_d;
  logic        trig_q, trig_d;
  logic        free_hit;

  sva_pkg::tok_t    tok_q, tok_d;
  logic [IDX_W-1:0] tok_idx_q, tok_idx_d;

  always_comb begin
    used_d   = used_q;
    gate_d   = gate_q;
    note_d   = note_q;
    age_d    = age_q;
    quiet_d  = quiet_q;
    trig_d   = trig_q;
    free_hit = used_q && !gate_q && (quiet_q > cmd_i.limit);
    if (cmd_i.valid) begin
      case (cmd_i.func)
        sva_pkg::FUNC_NOTE_ON: begin
          if (pick_i == MyIdx) begin
            used_d  = 1'b1;
            gate_d  = 1'b1;
            note_d  = cmd_i.note;
            age_d   = cmd_i.age;
            quiet_d = '0;
            trig_d  = 1'b1;
          end
        end
        sva_pkg::FUNC_NOTE_OFF: begin
          if (used_q && gate_q && (note_q == cmd_i.note)) begin
            gate_d = 1'b0;
          end
        end
        sva_pkg::FUNC_ALL_OFF: begin
          gate_d = 1'b0;
        end
        sva_pkg::FUNC_SAMPLE: begin
          if (used_q) begin
            if (gate_q) begin
              quiet_d = '0;
            end else if (cmd_i.level < cmd_i.floor_lvl) begin
              if (quiet_q != '1) begin
                quiet_d = quiet_q + 16'd1;
              end
            end else begin
              quiet_d = '0;
            end
          end
          trig_d = 1'b0;
        end
        sva_pkg::FUNC_BLOCK_END: begin
          if (free_hit) begin
            used_d  = 1'b0;
            quiet_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // The first unused voice wins; among used voices the smallest age wins, lower index on a tie.
  always_comb begin
    tok_d     = tok_i;
    tok_idx_d = tok_idx_i;
    if ((CELL_IDX == 0) || !tok_i.free) begin
      if (!used_q) begin
        tok_d.free = 1'b1;
        tok_d.age  = age_q;
        tok_idx_d  = MyIdx;
      end else if ((CELL_IDX == 0) || (age_q < tok_i.age)) begin
        tok_d.free = 1'b0;
        tok_d.age  = age_q;
        tok_idx_d  = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      gate_q    <= 1'b0;
      note_q    <= '0;
      age_q     <= '0;
      quiet_q   <= '0;
      trig_q    <= 1'b0;
      tok_q     <= '0;
      tok_idx_q <= '0;
    end else begin
      used_q    <= used_d;
      gate_q    <= gate_d;
      note_q    <= note_d;
      age_q     <= age_d;
      quiet_q   <= quiet_d;
      trig_q    <= trig_d;
      tok_q     <= tok_d;
      tok_idx_q <= tok_idx_d;
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;

  always_comb begin
    sts_o.used_nx  = used_d;
    sts_o.gate_nx  = gate_d;
    sts_o.free_hit = free_hit;
    sts_o.trig     = trig_q;
  end

endmodule
`default_nettype wire

### dv/synth_voice_allocator_checker.sv
`timescale 1ns / 1ps
// Watches the voice allocator channels, predicts every result and compares it field by field.
module synth_voice_allocator_checker #(
  parameter int unsigned VOICES = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sva_in_if          in_i,
  sva_out_if         out_i,
  sva_cfg_if         cfg_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [2:0]  voice_index;
    logic        stolen;
    logic [15:0] random_value;
    logic [7:0]  gate_mask;
    logic [7:0]  used_mask;
    logic [7:0]  freed_mask;
    logic [7:0]  trigger_mask;
  } voice_result_t;

  logic [VOICES-1:0] v_used;
  logic [VOICES-1:0] v_gate;
  logic [VOICES-1:0] v_trig;
  logic [6:0]        v_note  [VOICES];
  logic [31:0]       v_age   [VOICES];
  logic [15:0]       v_quiet [VOICES];
  logic [31:0]       age_count;
  logic [31:0]       lcg_state;
  logic [15:0]       floor_q;
  logic [15:0]       limit_q;

  voice_result_t expected_voice_results[$];
  voice_result_t want;
  int unsigned   mismatches;

  function automatic voice_result_t advance_voices(input logic [2:0] func, input logic [6:0] note,
                                                   input logic [15:0] level);
    voice_result_t r;
    int            pick;
    logic [31:0]   oldest;
    r = '0;
    case (func)
      sva_pkg::FUNC_NOTE_ON: begin
        pick = -1;
        for (int i = 0; i < VOICES; i++) begin
          if (!v_used[i]) begin
            pick = i;
            break;
          end
        end
        if (pick < 0) begin
          pick = 0;
          oldest = v_age[0];
          for (int i = 1; i < VOICES; i++) begin
            if (v_age[i] < oldest) begin
              oldest = v_age[i];
              pick = i;
            end
          end
          r.stolen = 1'b1;
        end
        age_count = age_count + 32'd1;
        lcg_state = lcg_state * sva_pkg::LCG_MUL + sva_pkg::LCG_ADD;
        v_used[pick]  = 1'b1;
        v_gate[pick]  = 1'b1;
        v_note[pick]  = note;
        v_age[pick]   = age_count;
        v_quiet[pick] = '0;
        v_trig[pick]  = 1'b1;
        r.voice_index  = pick[2:0];
        r.random_value = lcg_state[24:9];
      end
      sva_pkg::FUNC_NOTE_OFF: begin
        for (int i = 0; i < VOICES; i++) begin
          if (v_used[i] && v_gate[i] && v_note[i] == note) begin
            v_gate[i] = 1'b0;
          end
        end
      end
      sva_pkg::FUNC_ALL_OFF: begin
        v_gate = '0;
      end
      sva_pkg::FUNC_SAMPLE: begin
        for (int i = 0; i < VOICES; i++) begin
          if (v_used[i]) begin
            if (v_gate[i]) begin
              v_quiet[i] = '0;
            end else if (level < floor_q) begin
              if (v_quiet[i] != 16'hffff) begin
                v_quiet[i] = v_quiet[i] + 16'd1;
              end
            end else begin
              v_quiet[i] = '0;
            end
          end
        end
        r.trigger_mask = v_trig[7:0];
        v_trig = '0;
      end
      sva_pkg::FUNC_BLOCK_END: begin
        for (int i = 0; i < VOICES; i++) begin
          if (v_used[i] && !v_gate[i] && v_quiet[i] > limit_q) begin
            v_used[i]  = 1'b0;
            v_quiet[i] = '0;
            r.freed_mask[i] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.gate_mask = v_gate[7:0];
    r.used_mask = v_used[7:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_used    = '0;
      v_gate    = '0;
      v_trig    = '0;
      for (int i = 0; i < VOICES; i++) begin
        v_note[i]  = '0;
        v_age[i]   = '0;
        v_quiet[i] = '0;
      end
      age_count  = '0;
      lcg_state  = '0;
      floor_q    = sva_pkg::FLOOR_RESET;
      limit_q    = sva_pkg::LIMIT_RESET;
      mismatches = 0;
      expected_voice_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_voice_results.size() == 0) begin
          $error("result item arrived with no input item waiting");
          mismatches++;
        end else begin
          want = expected_voice_results.pop_front();
          check_field("voice_index", want.voice_index, out_i.voice_index);
          check_field("stolen", want.stolen, out_i.stolen);
          check_field("random_value", want.random_value, out_i.random_value);
          check_field("gate_mask", want.gate_mask, out_i.gate_mask);
          check_field("used_mask", want.used_mask, out_i.used_mask);
          check_field("freed_mask", want.freed_mask, out_i.freed_mask);
          check_field("trigger_mask", want.trigger_mask, out_i.trigger_mask);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == sva_pkg::CFG_FLOOR_LEVEL) begin
          floor_q = cfg_i.data;
        end else if (cfg_i.index == sva_pkg::CFG_QUIET_LIMIT) begin
          limit_q = cfg_i.data;
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_voice_results.push_back(advance_voices(in_i.func, in_i.note_number,
                                                        in_i.mix_level));
      end
      pending_o    <= expected_voice_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### dv/synth_voice_allocator_core_test.sv
`timescale 1ns / 1ps
// Testbench top: drives directed and random items into the voice allocator and gives the verdict.
module synth_voice_allocator_core_test;

  localparam int unsigned VOICES        = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = VOICES + 4;
  localparam int unsigned QUIET_STEPS   = 4;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 260;
  localparam logic [15:0] PHASE_FLOOR [PHASES] = '{16'd300, 16'hffff, 16'd0, 16'h8000, 16'd40};
  localparam logic [15:0] PHASE_LIMIT [PHASES] = '{16'd2, 16'd0, 16'd0, 16'd6, 16'd1};

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned cycles;
  logic [15:0] floor_now;

  sva_in_if  in_ch ();
  sva_out_if out_ch ();
  sva_cfg_if cfg_ch ();

  synth_voice_allocator_core #(
    .VOICES(VOICES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  synth_voice_allocator_checker #(
    .VOICES(VOICES)
  ) result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .cfg_i       (cfg_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic send_item(input logic [2:0] func, input logic [6:0] note,
                           input logic [6:0] vel, input logic [15:0] level);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= func;
    in_ch.note_number   <= note;
    in_ch.note_velocity <= vel;
    in_ch.mix_level     <= level;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_results;
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == sva_pkg::CFG_FLOOR_LEVEL) begin
      floor_now = data;
    end
    @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_note();
    if ($urandom_range(0, 3) == 0) begin
      return 7'($urandom_range(0, 127));
    end
    return 7'(60 + $urandom_range(0, 5));
  endfunction

  task automatic send_random_item;
    int unsigned roll;
    logic [2:0]  func;
    logic [15:0] level;
    roll  = $urandom_range(0, 99);
    level = 16'($urandom_range(0, 65535));
    if (roll < 22) begin
      func = sva_pkg::FUNC_NOTE_ON;
    end else if (roll < 36) begin
      func = sva_pkg::FUNC_NOTE_OFF;
    end else if (roll < 39) begin
      func = sva_pkg::FUNC_ALL_OFF;
    end else if (roll < 80) begin
      func = sva_pkg::FUNC_SAMPLE;
      if (floor_now != 0 && $urandom_range(0, 9) < 7) begin
        level = 16'($urandom_range(0, floor_now - 1));
      end
    end else if (roll < 96) begin
      func = sva_pkg::FUNC_BLOCK_END;
    end else begin
      func = 3'($urandom_range(sva_pkg::FUNC_BLOCK_END + 1, 7));
    end
    send_item(func, pick_note(), 7'($urandom_range(0, 127)), level);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    hold_reqs <= hold_reqs + 1;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < count; b++) begin
        send_random_item();
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    holds_done   = 0;
    mode         = 0;
    mode_left    = 0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_reqs) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
          if (mode == 1 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
          end else if (mode == 2 && $urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("synth_voice_allocator_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = sva_pkg::FUNC_NOTE_ON;
    in_ch.note_number   = '0;
    in_ch.note_velocity = '0;
    in_ch.mix_level     = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    hold_reqs           = 0;
    floor_now           = sva_pkg::FLOOR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every voice, then steal the two oldest.
    send_item(sva_pkg::FUNC_NOTE_ON, 7'd0, 7'd0, 16'd0);
    send_item(sva_pkg::FUNC_NOTE_ON, 7'd127, 7'd127, 16'hffff);
    for (int i = 0; i < VOICES - 2; i++) begin
      send_item(sva_pkg::FUNC_NOTE_ON, 7'd60, 7'($urandom_range(0, 127)), 16'd0);
    end
    send_item(sva_pkg::FUNC_NOTE_ON, 7'd61, 7'd64, 16'd0);
    send_item(sva_pkg::FUNC_NOTE_ON, 7'd62, 7'd1, 16'd0);
    send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'd0);
    send_item(sva_pkg::FUNC_NOTE_OFF, 7'd60, 7'd0, 16'd0);
    send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'd3);
    send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'hffff);
    send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'd0);
    send_item(sva_pkg::FUNC_BLOCK_END, 7'd0, 7'd0, 16'd0);
    send_item(sva_pkg::FUNC_ALL_OFF, 7'd0, 7'd0, 16'd0);
    for (int c = sva_pkg::FUNC_BLOCK_END + 1; c < 8; c++) begin
      send_item(3'(c), 7'h7f, 7'h7f, 16'hffff);
    end
    send_item(sva_pkg::FUNC_NOTE_ON, 7'd5, 7'd100, 16'd0);
    send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'd0);
    wait_results();

    // Count quiet samples on released voices at the widest floor and limit, then free them.
    write_reg(sva_pkg::CFG_FLOOR_LEVEL, 16'hffff);
    write_reg(sva_pkg::CFG_QUIET_LIMIT, 16'hffff);
    send_item(sva_pkg::FUNC_ALL_OFF, 7'd0, 7'd0, 16'd0);
    for (int unsigned i = 0; i < QUIET_STEPS; i++) begin
      send_item(sva_pkg::FUNC_SAMPLE, 7'd0, 7'd0, 16'd0);
    end
    send_item(sva_pkg::FUNC_BLOCK_END, 7'd0, 7'd0, 16'd0);
    wait_results();
    write_reg(sva_pkg::CFG_QUIET_LIMIT, 16'd2);
    send_item(sva_pkg::FUNC_BLOCK_END, 7'd0, 7'd0, 16'd0);
    wait_results();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(sva_pkg::CFG_FLOOR_LEVEL, PHASE_FLOOR[p]);
      write_reg(sva_pkg::CFG_QUIET_LIMIT, PHASE_LIMIT[p]);
      random_phase(PHASE_ITEMS);
      wait_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("synth_voice_allocator_core test passed");
    end else begin
      $display("synth_voice_allocator_core test failed");
    end
    $finish;
  end

endmodule
